// ===== hw/rtl/tmw_pkg.sv =====
// tmw_pkg: shared constants, item codes, control structs and byte decoders
// for the text-mode terminal writer. No dependencies; used by every other file but tmw_ram.
package tmw_pkg;

    // default screen geometry
    localparam int DEFAULT_COLS = 80;
    localparam int DEFAULT_ROWS = 25;

    // port field widths
    localparam int KIND_W      = 2;
    localparam int BYTE_W      = 8;
    localparam int CELL_ADDR_W = 11;
    localparam int COLUMN_W    = 7;
    localparam int LINE_W      = 5;
    localparam int CELL_W      = 16;
    localparam int ATTR_W      = 8;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_PUT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SCROLL = 2'd2;

    // special bytes
    localparam logic [BYTE_W-1:0] BYTE_ESC   = 8'h1B;
    localparam logic [BYTE_W-1:0] BYTE_END   = 8'h3B;
    localparam logic [BYTE_W-1:0] BYTE_ONE   = 8'h31;
    localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0D;

    // attribute and blank cell after reset
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
    localparam logic [CELL_W-1:0] BLANK_CELL = {ATTR_RESET, BYTE_SPACE};

    // escape parser phases
    localparam logic [1:0] PH_NONE    = 2'd0;
    localparam logic [1:0] PH_ESCAPED = 2'd1;
    localparam logic [1:0] PH_VALUE   = 2'd2;

    // escape targets
    localparam logic [2:0] TG_UNKNOWN = 3'd0;
    localparam logic [2:0] TG_FG      = 3'd1;
    localparam logic [2:0] TG_BG      = 3'd2;
    localparam logic [2:0] TG_BLINK   = 3'd3;
    localparam logic [2:0] TG_END     = 3'd4;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic read_done;
        logic copy_step;
        logic blank_step;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic item_read;
        logic item_sweep;
        logic copy_empty;
        logic copy_last;
        logic blank_last;
    } dp_status_t;

    // hex digit value, zero for anything else
    function automatic logic [3:0] hex_value(input logic [BYTE_W-1:0] b);
        logic [3:0] v;
        v = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            v = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            v = 4'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            v = 4'(b - 8'h37);
        end
        return v;
    endfunction

    // target picked by the byte after an escape
    function automatic logic [2:0] target_of(input logic [BYTE_W-1:0] b);
        logic [2:0] t;
        case (b)
            8'h46, 8'h66: t = TG_FG;
            8'h42, 8'h62: t = TG_BG;
            8'h4B, 8'h6B: t = TG_BLINK;
            BYTE_END:     t = TG_END;
            default:      t = TG_UNKNOWN;
        endcase
        return t;
    endfunction

endpackage

// ===== hw/rtl/tmw_if.sv =====
// tmw_if: valid/ready channels for items in and results out
// depends on tmw_pkg for field widths
interface tmw_item_if;
    logic                                valid;
    logic                                ready;
    logic [tmw_pkg::KIND_W-1:0]          kind;
    logic [tmw_pkg::BYTE_W-1:0]          byte_value;
    logic [tmw_pkg::CELL_ADDR_W-1:0]     cell_address;

    modport source (output valid, kind, byte_value, cell_address, input ready);
    modport sink   (input valid, kind, byte_value, cell_address, output ready);
endinterface

interface tmw_result_if;
    logic                                valid;
    logic                                ready;
    logic                                printed;
    logic [tmw_pkg::COLUMN_W-1:0]        cursor_column;
    logic [tmw_pkg::LINE_W-1:0]          cursor_line;
    logic [tmw_pkg::CELL_W-1:0]          cell_data;
    logic [tmw_pkg::ATTR_W-1:0]          attribute_now;

    modport source (output valid, printed, cursor_column, cursor_line, cell_data,
                    attribute_now, input ready);
    modport sink   (input valid, printed, cursor_column, cursor_line, cell_data,
                    attribute_now, output ready);
endinterface

// ===== hw/rtl/tmw_ram.sv =====
// tmw_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module tmw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tmw_dp.sv =====
// tmw_dp: datapath - cursor, attribute, escape parser, sweep counter and screen store
// depends on tmw_pkg and tmw_ram
module tmw_dp #(
    parameter int SCREEN_COLS = tmw_pkg::DEFAULT_COLS,
    parameter int SCREEN_ROWS = tmw_pkg::DEFAULT_ROWS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tmw_pkg::dp_cmd_t                  cmd,
    output tmw_pkg::dp_status_t               status,
    input  logic [tmw_pkg::KIND_W-1:0]        kind,
    input  logic [tmw_pkg::BYTE_W-1:0]        byte_value,
    input  logic [tmw_pkg::CELL_ADDR_W-1:0]   cell_address,
    output logic                              printed,
    output logic [tmw_pkg::COLUMN_W-1:0]      cursor_column,
    output logic [tmw_pkg::LINE_W-1:0]        cursor_line,
    output logic [tmw_pkg::CELL_W-1:0]        cell_data,
    output logic [tmw_pkg::ATTR_W-1:0]        attribute_now
);

    localparam int CELLS     = SCREEN_COLS * SCREEN_ROWS;
    localparam int ADDR_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int COL_W     = (SCREEN_COLS > 1) ? $clog2(SCREEN_COLS) : 1;
    localparam int ROW_W     = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
    localparam int COPY_LAST = (SCREEN_ROWS > 1) ? CELLS - SCREEN_COLS - 1 : 0;

    logic [COL_W-1:0]               col_reg, col_next;
    logic [ROW_W-1:0]               row_reg, row_next;
    logic [tmw_pkg::ATTR_W-1:0]     attr_reg, attr_next;
    logic [1:0]                     phase_reg, phase_next;
    logic [2:0]                     target_reg, target_next;
    logic [ADDR_W-1:0]              sweep_reg;
    logic                           wr_pend_reg;
    logic [ADDR_W-1:0]              wr_addr_reg;
    logic                           in_range_reg;
    logic                           printed_reg;
    logic [tmw_pkg::CELL_W-1:0]     cell_data_reg;

    logic                           is_put, is_read, is_scroll;
    logic                           esc_open, col_last, row_last;
    logic                           put_write, put_printed, put_scroll;
    logic [3:0]                     hex;
    logic [ADDR_W-1:0]              cell_index;
    logic                           in_range;

    logic                           ram_we, ram_re;
    logic [ADDR_W-1:0]              ram_waddr, ram_raddr;
    logic [tmw_pkg::CELL_W-1:0]     ram_wdata, ram_rdata;

    assign is_put    = (kind == tmw_pkg::KIND_PUT);
    assign is_read   = (kind == tmw_pkg::KIND_READ);
    assign is_scroll = (kind == tmw_pkg::KIND_SCROLL);
    assign esc_open  = (phase_reg == tmw_pkg::PH_ESCAPED) || (phase_reg == tmw_pkg::PH_VALUE);
    assign col_last  = (col_reg == COL_W'(SCREEN_COLS - 1));
    assign row_last  = (row_reg == ROW_W'(SCREEN_ROWS - 1));
    assign hex       = tmw_pkg::hex_value(byte_value);
    assign cell_index = ADDR_W'(int'(row_reg) * SCREEN_COLS + int'(col_reg));
    assign in_range  = (32'(cell_address) < 32'(CELLS));

    // item decode: next cursor, attribute and parser state
    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        attr_next   = attr_reg;
        phase_next  = phase_reg;
        target_next = target_reg;
        put_write   = 1'b0;
        put_printed = 1'b0;
        put_scroll  = 1'b0;
        if (is_put)
        begin
            if (esc_open || byte_value == tmw_pkg::BYTE_ESC)
            begin
                case (phase_reg)
                    tmw_pkg::PH_ESCAPED:
                    begin
                        target_next = tmw_pkg::target_of(byte_value);
                        if (target_next == tmw_pkg::TG_END)
                        begin
                            phase_next = tmw_pkg::PH_NONE;
                        end
                        else if (target_next != tmw_pkg::TG_UNKNOWN)
                        begin
                            phase_next = tmw_pkg::PH_VALUE;
                        end
                    end
                    tmw_pkg::PH_VALUE:
                    begin
                        case (target_reg)
                            tmw_pkg::TG_FG:    attr_next = {attr_reg[7:4], hex};
                            tmw_pkg::TG_BG:    attr_next = {attr_reg[7], hex[2:0], attr_reg[3:0]};
                            tmw_pkg::TG_BLINK: attr_next = {byte_value == tmw_pkg::BYTE_ONE,
                                                            attr_reg[6:0]};
                            default:           attr_next = attr_reg;
                        endcase
                        phase_next = tmw_pkg::PH_ESCAPED;
                    end
                    default:
                    begin
                        phase_next = tmw_pkg::PH_ESCAPED;
                    end
                endcase
            end
            else if (byte_value == tmw_pkg::BYTE_LF)
            begin
                col_next = '0;
                if (row_last)
                begin
                    put_scroll = 1'b1;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            else if (byte_value == tmw_pkg::BYTE_CR)
            begin
                col_next = '0;
            end
            else
            begin
                put_write   = 1'b1;
                put_printed = 1'b1;
                if (col_last)
                begin
                    col_next = '0;
                    if (row_last)
                    begin
                        put_scroll = 1'b1;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        end
        else if (is_scroll && row_reg != '0)
        begin
            put_scroll = 1'b1;
            row_next   = row_reg - 1'b1;
        end
    end

    // status towards the controller
    always_comb
    begin
        status.item_read  = is_read;
        status.item_sweep = put_scroll;
        status.copy_empty = (SCREEN_ROWS == 1);
        status.copy_last  = (sweep_reg == ADDR_W'(COPY_LAST));
        status.blank_last = !wr_pend_reg && (sweep_reg == ADDR_W'(CELLS - 1));
    end

    // cursor, attribute and escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            attr_reg   <= tmw_pkg::ATTR_RESET;
            phase_reg  <= tmw_pkg::PH_NONE;
            target_reg <= tmw_pkg::TG_UNKNOWN;
        end
        else if (cmd.accept)
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            attr_reg   <= attr_next;
            phase_reg  <= phase_next;
            target_reg <= target_next;
        end
    end

    // sweep counter for scroll copy, row blanking and clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg   <= '0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            wr_pend_reg <= cmd.copy_step;
            if (cmd.copy_step)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            else if (cmd.blank_step && !wr_pend_reg)
            begin
                sweep_reg <= status.blank_last ? '0 : sweep_reg + 1'b1;
            end
        end
    end

    // copy write address and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.copy_step)
        begin
            wr_addr_reg <= sweep_reg;
        end
        if (cmd.accept)
        begin
            printed_reg   <= put_printed;
            cell_data_reg <= '0;
            in_range_reg  <= in_range;
        end
        else if (cmd.read_done)
        begin
            cell_data_reg <= in_range_reg ? ram_rdata : '0;
        end
    end

    // screen store port selection
    always_comb
    begin
        ram_we    = (cmd.accept && put_write) || wr_pend_reg || cmd.blank_step;
        ram_waddr = cell_index;
        ram_wdata = {attr_reg, byte_value};
        if (wr_pend_reg)
        begin
            ram_waddr = wr_addr_reg;
            ram_wdata = ram_rdata;
        end
        else if (cmd.blank_step)
        begin
            ram_waddr = sweep_reg;
            ram_wdata = tmw_pkg::BLANK_CELL;
        end
        ram_re    = (cmd.accept && is_read) || cmd.copy_step;
        ram_raddr = cmd.copy_step ? ADDR_W'(int'(sweep_reg) + SCREEN_COLS)
                                  : ADDR_W'(cell_address);
    end

    tmw_ram #(
        .WIDTH (tmw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign printed       = printed_reg;
    assign cell_data     = cell_data_reg;
    assign cursor_column = tmw_pkg::COLUMN_W'(col_reg);
    assign cursor_line   = tmw_pkg::LINE_W'(row_reg);
    assign attribute_now = attr_reg;

endmodule

// ===== hw/rtl/tmw_ctrl.sv =====
// tmw_ctrl: controller state machine - clearing pass, item acceptance, read,
// scroll copy and row blanking; depends on tmw_pkg
module tmw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  tmw_pkg::dp_status_t   status,
    output tmw_pkg::dp_cmd_t      cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_COPY  = 3'd3;
    localparam logic [2:0] ST_BLANK = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       load;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        load       = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.blank_step = 1'b1;
                if (status.blank_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.accept = 1'b1;
                    if (status.item_read)
                    begin
                        state_next = ST_READ;
                    end
                    else if (status.item_sweep)
                    begin
                        state_next = status.copy_empty ? ST_BLANK : ST_COPY;
                    end
                    else
                    begin
                        load = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                cmd.read_done = 1'b1;
                load          = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (status.copy_last)
                begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK:
            begin
                cmd.blank_step = 1'b1;
                if (status.blank_last)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = load || (out_valid_reg && !out_ready);
    end

    // state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/text_mode_terminal_writer.sv =====
// text_mode_terminal_writer: top level joining controller and datapath
// depends on tmw_pkg, tmw_if, tmw_ctrl and tmw_dp
//
// After reset the screen store is cleared to blank white-on-black cells, one cell a
// cycle, so no item is taken until every cell is clear. A put item that neither
// wraps past the last row nor opens a scroll, a carriage return, an escape byte, an
// unused kind and a scroll item with the cursor on the top row are handled in the
// idle state, their result registered; a read item passes through the read state
// first (registered read of the store). A scroll, forced or caused by a newline or a
// wrap on the last row, passes through the copy and blank states (only the blank
// state on a one-row screen, where there is nothing to copy) and uses the one write
// port of the screen store: every cell of rows 1 and below is copied up one row and
// the last row is blanked, one cell a cycle. One result comes back per item.
module text_mode_terminal_writer #(
    parameter int SCREEN_COLS = tmw_pkg::DEFAULT_COLS,
    parameter int SCREEN_ROWS = tmw_pkg::DEFAULT_ROWS
) (
    input  logic          clk,
    input  logic          rst_n,
    tmw_item_if.sink      item,
    tmw_result_if.source  result
);

    tmw_pkg::dp_cmd_t    cmd;
    tmw_pkg::dp_status_t status;

    // controller
    tmw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    tmw_dp #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .kind          (item.kind),
        .byte_value    (item.byte_value),
        .cell_address  (item.cell_address),
        .printed       (result.printed),
        .cursor_column (result.cursor_column),
        .cursor_line   (result.cursor_line),
        .cell_data     (result.cell_data),
        .attribute_now (result.attribute_now)
    );

    // an item is only taken when its result has somewhere to go
    a_accept_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |-> (!result.valid || result.ready))
        else $error("item accepted while result slot busy");

    // cursor stays on the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ((32'(result.cursor_column) < SCREEN_COLS)
                          && (32'(result.cursor_line) < SCREEN_ROWS)))
        else $error("cursor outside the screen");

    // a read result needs the store's registered read cycle
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && item.kind == tmw_pkg::KIND_READ) |=> !result.valid)
        else $error("read result shown without store latency");

endmodule

// ===== verif/tb_text_mode_terminal_writer.sv =====
// tb_text_mode_terminal_writer: self-checking testbench for the text-mode terminal writer
// depends on tmw_pkg, tmw_if and text_mode_terminal_writer; keeps a shadow screen,
// cursor and escape parser, and checks every result transaction against it
module tb_text_mode_terminal_writer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS          = tmw_pkg::DEFAULT_COLS;
    localparam int ROWS          = tmw_pkg::DEFAULT_ROWS;
    localparam int CELLS         = COLS * ROWS;
    localparam int RANDOM_ITEMS  = 330;
    localparam int MODE_SPAN     = 60;
    localparam int REPORT_MAX    = 10;
    localparam int SETTLE_CYCLES = CELLS + 10;
    localparam int CYCLE_LIMIT   = 4_000_000;

    // unused item kind, no state change
    localparam logic [tmw_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    // bytes used by the escape parser and the stimulus
    localparam logic [tmw_pkg::BYTE_W-1:0] CH_FG_UP     = "F";
    localparam logic [tmw_pkg::BYTE_W-1:0] CH_FG_LO     = "f";
    localparam logic [tmw_pkg::BYTE_W-1:0] CH_BG_UP     = "B";
    localparam logic [tmw_pkg::BYTE_W-1:0] CH_BG_LO     = "b";
    localparam logic [tmw_pkg::BYTE_W-1:0] CH_BLINK_UP  = "K";
    localparam logic [tmw_pkg::BYTE_W-1:0] CH_BLINK_LO  = "k";
    localparam logic [tmw_pkg::BYTE_W-1:0] CH_ZERO      = "0";
    localparam logic [tmw_pkg::BYTE_W-1:0] CH_NINE      = "9";
    localparam logic [tmw_pkg::BYTE_W-1:0] CH_HEX_A_LO  = "a";
    localparam logic [tmw_pkg::BYTE_W-1:0] CH_HEX_F_LO  = "f";
    localparam logic [tmw_pkg::BYTE_W-1:0] CH_HEX_A_UP  = "A";
    localparam logic [tmw_pkg::BYTE_W-1:0] CH_HEX_F_UP  = "F";
    localparam logic [tmw_pkg::BYTE_W-1:0] CH_HEX_E     = "e";
    localparam logic [tmw_pkg::BYTE_W-1:0] CH_HEX_C     = "c";
    localparam logic [tmw_pkg::BYTE_W-1:0] CH_NOT_HEX   = "Z";
    localparam logic [tmw_pkg::BYTE_W-1:0] CH_NO_TARGET = "x";
    localparam logic [tmw_pkg::BYTE_W-1:0] CH_LETTER_A  = "A";
    localparam logic [tmw_pkg::BYTE_W-1:0] CH_PRINT_LO  = 8'h20;
    localparam logic [tmw_pkg::BYTE_W-1:0] CH_PRINT_HI  = 8'h7E;

    // idling modes, cycled through as transactions are accepted
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [tmw_pkg::KIND_W-1:0]      kind;
        logic [tmw_pkg::BYTE_W-1:0]      byte_value;
        logic [tmw_pkg::CELL_ADDR_W-1:0] cell_address;
    } term_item_t;

    typedef struct packed {
        logic                         printed;
        logic [tmw_pkg::COLUMN_W-1:0] cursor_column;
        logic [tmw_pkg::LINE_W-1:0]   cursor_line;
        logic [tmw_pkg::CELL_W-1:0]   cell_data;
        logic [tmw_pkg::ATTR_W-1:0]   attribute_now;
    } term_status_t;

    logic clk;
    logic rst_n;

    tmw_item_if   in_ch ();
    tmw_result_if out_ch ();

    text_mode_terminal_writer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_ch),
        .result (out_ch)
    );

    // shadow of the terminal state
    logic [tmw_pkg::CELL_W-1:0] shadow_cells [CELLS];
    int                         shadow_col;
    int                         shadow_row;
    logic [tmw_pkg::ATTR_W-1:0] shadow_attr;
    logic [1:0]                 shadow_phase;
    logic [2:0]                 shadow_target;

    term_item_t   items_to_send [$];
    term_status_t status_due [$];
    term_item_t   next_item;
    int           items_total;
    int           items_accepted;
    int           fail_count;
    int           cycle_count;
    logic         in_fired;
    string        hex_digits = "0123456789abcdefABCDEF";
    string        target_letters = "FfBbKk";

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // value of a hex digit byte, zero for anything else
    function automatic logic [3:0] nibble_of(input logic [tmw_pkg::BYTE_W-1:0] b);
        logic [3:0] v;
        v = 4'd0;
        if (b >= CH_ZERO && b <= CH_NINE)
        begin
            v = 4'(b - CH_ZERO);
        end
        else if (b >= CH_HEX_A_LO && b <= CH_HEX_F_LO)
        begin
            v = 4'(b - CH_HEX_A_LO + 10);
        end
        else if (b >= CH_HEX_A_UP && b <= CH_HEX_F_UP)
        begin
            v = 4'(b - CH_HEX_A_UP + 10);
        end
        return v;
    endfunction

    // escape target named by the byte after an escape
    function automatic logic [2:0] target_for(input logic [tmw_pkg::BYTE_W-1:0] b);
        logic [2:0] t;
        t = tmw_pkg::TG_UNKNOWN;
        if (b == CH_FG_UP || b == CH_FG_LO)
        begin
            t = tmw_pkg::TG_FG;
        end
        else if (b == CH_BG_UP || b == CH_BG_LO)
        begin
            t = tmw_pkg::TG_BG;
        end
        else if (b == CH_BLINK_UP || b == CH_BLINK_LO)
        begin
            t = tmw_pkg::TG_BLINK;
        end
        else if (b == tmw_pkg::BYTE_END)
        begin
            t = tmw_pkg::TG_END;
        end
        return t;
    endfunction

    // move rows up by one and blank the last; nothing when the cursor is on row 0
    function automatic void shadow_scroll();
        int i;
        if (shadow_row == 0)
        begin
            return;
        end
        for (i = 0; i < CELLS - COLS; i++)
        begin
            shadow_cells[i] = shadow_cells[i + COLS];
        end
        for (i = CELLS - COLS; i < CELLS; i++)
        begin
            shadow_cells[i] = tmw_pkg::BLANK_CELL;
        end
        shadow_row--;
    endfunction

    function automatic void shadow_newline();
        shadow_col = 0;
        shadow_row++;
        if (shadow_row >= ROWS)
        begin
            shadow_scroll();
        end
    endfunction

    // one byte through the escape parser
    function automatic void shadow_escape(input logic [tmw_pkg::BYTE_W-1:0] b);
        logic [3:0] v;
        v = nibble_of(b);
        if (shadow_phase == tmw_pkg::PH_ESCAPED)
        begin
            shadow_target = target_for(b);
            if (shadow_target == tmw_pkg::TG_END)
            begin
                shadow_phase = tmw_pkg::PH_NONE;
            end
            else if (shadow_target != tmw_pkg::TG_UNKNOWN)
            begin
                shadow_phase = tmw_pkg::PH_VALUE;
            end
        end
        else if (shadow_phase == tmw_pkg::PH_VALUE)
        begin
            case (shadow_target)
                tmw_pkg::TG_FG:    shadow_attr[3:0] = v;
                tmw_pkg::TG_BG:    shadow_attr[6:4] = v[2:0];
                tmw_pkg::TG_BLINK: shadow_attr[7] = (b == tmw_pkg::BYTE_ONE);
                default:           ;
            endcase
            shadow_phase = tmw_pkg::PH_ESCAPED;
        end
        else
        begin
            shadow_phase = tmw_pkg::PH_ESCAPED;
        end
    endfunction

    // put one byte, returns whether a visible cell was written
    function automatic logic shadow_put(input logic [tmw_pkg::BYTE_W-1:0] b);
        int addr;
        if (shadow_phase != tmw_pkg::PH_NONE || b == tmw_pkg::BYTE_ESC)
        begin
            shadow_escape(b);
            return 1'b0;
        end
        if (b == tmw_pkg::BYTE_LF)
        begin
            shadow_newline();
            return 1'b0;
        end
        if (b == tmw_pkg::BYTE_CR)
        begin
            shadow_col = 0;
            return 1'b0;
        end
        addr = shadow_row * COLS + shadow_col;
        if (addr < CELLS)
        begin
            shadow_cells[addr] = {shadow_attr, b};
        end
        shadow_col++;
        if (shadow_col >= COLS)
        begin
            shadow_newline();
        end
        return 1'b1;
    endfunction

    // apply one item to the shadow terminal and give the status it leads to
    function automatic term_status_t terminal_step(input term_item_t it);
        term_status_t s;
        s = '0;
        case (it.kind)
            tmw_pkg::KIND_PUT:
            begin
                s.printed = shadow_put(it.byte_value);
            end
            tmw_pkg::KIND_READ:
            begin
                if (it.cell_address < CELLS)
                begin
                    s.cell_data = shadow_cells[it.cell_address];
                end
            end
            tmw_pkg::KIND_SCROLL:
            begin
                shadow_scroll();
            end
            default: ;
        endcase
        s.cursor_column = tmw_pkg::COLUMN_W'(shadow_col);
        s.cursor_line   = tmw_pkg::LINE_W'(shadow_row);
        s.attribute_now = shadow_attr;
        return s;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            note_failure($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
        end
    endfunction

    function automatic void queue_item(input logic [tmw_pkg::KIND_W-1:0] kind,
                                       input logic [tmw_pkg::BYTE_W-1:0] b,
                                       input logic [tmw_pkg::CELL_ADDR_W-1:0] addr);
        term_item_t it;
        it.kind         = kind;
        it.byte_value   = b;
        it.cell_address = addr;
        items_to_send.push_back(it);
    endfunction

    // put item, the address field carries random junk
    function automatic void queue_put(input logic [tmw_pkg::BYTE_W-1:0] b);
        queue_item(tmw_pkg::KIND_PUT, b, tmw_pkg::CELL_ADDR_W'($urandom));
    endfunction

    function automatic idle_mode_t mode_now();
        return idle_mode_t'((items_accepted / MODE_SPAN) % 4);
    endfunction

    function automatic logic sender_pauses();
        case (mode_now())
            IDLE_SENDER: return $urandom_range(0, 99) < 64;
            IDLE_BOTH:   return $urandom_range(0, 99) < 23;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_stalls();
        case (mode_now())
            IDLE_RECEIVER: return $urandom_range(0, 99) < 64;
            IDLE_BOTH:     return $urandom_range(0, 99) < 23;
            default:       return 1'b0;
        endcase
    endfunction

    // item driver: next transaction once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_ch.valid || in_fired)
            begin
                if (items_to_send.size() > 0 && !sender_pauses())
                begin
                    next_item = items_to_send.pop_front();
                    in_ch.valid        <= 1'b1;
                    in_ch.kind         <= next_item.kind;
                    in_ch.byte_value   <= next_item.byte_value;
                    in_ch.cell_address <= next_item.cell_address;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_ch.ready <= !receiver_stalls();
        end
    end

    // monitor: predict on each accepted item, check each accepted result
    always @(posedge clk)
    begin
        cycle_count++;
        in_fired <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            status_due.push_back(terminal_step('{in_ch.kind, in_ch.byte_value,
                                                 in_ch.cell_address}));
            items_accepted++;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (status_due.size() == 0)
            begin
                note_failure("result transaction with nothing expected");
            end
            else
            begin
                term_status_t want;
                want = status_due.pop_front();
                check_field("printed", want.printed, out_ch.printed);
                check_field("cursor_column", want.cursor_column, out_ch.cursor_column);
                check_field("cursor_line", want.cursor_line, out_ch.cursor_line);
                check_field("cell_data", want.cell_data, out_ch.cell_data);
                check_field("attribute_now", want.attribute_now, out_ch.attribute_now);
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("** text_mode_terminal_writer: FAILED **");
        $finish;
    end

    // stimulus, reset and end of run
    initial
    begin
        int r;
        int k;
        int n;
        int i;
        logic [tmw_pkg::BYTE_W-1:0] letter;

        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.kind         = tmw_pkg::KIND_PUT;
        in_ch.byte_value   = '0;
        in_ch.cell_address = '0;
        out_ch.ready       = 1'b0;
        in_fired           = 1'b0;
        items_accepted     = 0;
        fail_count         = 0;
        cycle_count        = 0;

        // shadow state after reset
        for (i = 0; i < CELLS; i++)
        begin
            shadow_cells[i] = tmw_pkg::BLANK_CELL;
        end
        shadow_col    = 0;
        shadow_row    = 0;
        shadow_attr   = tmw_pkg::ATTR_RESET;
        shadow_phase  = tmw_pkg::PH_NONE;
        shadow_target = tmw_pkg::TG_UNKNOWN;

        // directed: reads at the ends of the store and past it, unused kind
        queue_item(tmw_pkg::KIND_READ, 8'h00, 11'd0);
        queue_item(tmw_pkg::KIND_READ, 8'hFF, tmw_pkg::CELL_ADDR_W'(CELLS - 1));
        queue_item(tmw_pkg::KIND_READ, 8'h00, tmw_pkg::CELL_ADDR_W'(CELLS));
        queue_item(tmw_pkg::KIND_READ, 8'h00, '1);
        queue_item(KIND_UNUSED, 8'hFF, '1);
        // scroll with the cursor on the top row does nothing
        queue_item(tmw_pkg::KIND_SCROLL, 8'h00, 11'd0);
        queue_put(CH_LETTER_A);
        // escape: foreground, non-hex value, unknown target, escape inside escape
        queue_put(tmw_pkg::BYTE_ESC);
        queue_put(CH_FG_UP);
        queue_put(CH_HEX_E);
        queue_put(CH_FG_LO);
        queue_put(CH_NOT_HEX);
        queue_put(CH_NO_TARGET);
        queue_put(tmw_pkg::BYTE_ESC);
        // background keeps three bits, blink on, then end
        queue_put(CH_BG_UP);
        queue_put(CH_HEX_C);
        queue_put(CH_BLINK_LO);
        queue_put(tmw_pkg::BYTE_ONE);
        queue_put(tmw_pkg::BYTE_END);
        queue_put(8'hFF);
        queue_put(tmw_pkg::BYTE_LF);
        queue_put(tmw_pkg::BYTE_CR);
        queue_item(tmw_pkg::KIND_SCROLL, 8'hFF, '1);
        queue_item(tmw_pkg::KIND_READ, 8'h00, 11'd0);

        // random sequences
        while (items_to_send.size() < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                // text run, often closed by a newline
                n = $urandom_range(1, 12);
                repeat (n)
                begin
                    k = $urandom_range(0, 99);
                    if (k < 85)
                    begin
                        queue_put(tmw_pkg::BYTE_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)));
                    end
                    else
                    begin
                        queue_put(tmw_pkg::BYTE_W'($urandom_range(0, 255)));
                    end
                end
                k = $urandom_range(0, 99);
                if (k < 60)
                begin
                    queue_put(tmw_pkg::BYTE_LF);
                end
                else if (k < 70)
                begin
                    queue_put(tmw_pkg::BYTE_CR);
                end
            end
            else if (r < 55)
            begin
                // well-formed escape sequence
                queue_put(tmw_pkg::BYTE_ESC);
                n = $urandom_range(1, 3);
                repeat (n)
                begin
                    letter = target_letters[$urandom_range(0, 5)];
                    queue_put(letter);
                    k = $urandom_range(0, 99);
                    if (letter == CH_BLINK_UP || letter == CH_BLINK_LO)
                    begin
                        if (k < 45)
                        begin
                            queue_put(tmw_pkg::BYTE_ONE);
                        end
                        else if (k < 90)
                        begin
                            queue_put(CH_ZERO);
                        end
                        else
                        begin
                            queue_put(tmw_pkg::BYTE_W'($urandom_range(0, 255)));
                        end
                    end
                    else if (k < 90)
                    begin
                        queue_put(hex_digits[$urandom_range(0, 21)]);
                    end
                    else
                    begin
                        queue_put(tmw_pkg::BYTE_W'($urandom_range(0, 255)));
                    end
                end
                queue_put(tmw_pkg::BYTE_END);
            end
            else if (r < 60)
            begin
                // burst of newlines to reach the bottom row
                n = $urandom_range(2, 6);
                repeat (n)
                begin
                    queue_put(tmw_pkg::BYTE_LF);
                end
            end
            else if (r < 74)
            begin
                k = $urandom_range(0, 99);
                if (k < 90)
                begin
                    queue_item(tmw_pkg::KIND_READ, tmw_pkg::BYTE_W'($urandom),
                               tmw_pkg::CELL_ADDR_W'($urandom_range(0, CELLS - 1)));
                end
                else
                begin
                    queue_item(tmw_pkg::KIND_READ, tmw_pkg::BYTE_W'($urandom),
                               tmw_pkg::CELL_ADDR_W'($urandom));
                end
            end
            else if (r < 78)
            begin
                queue_item(tmw_pkg::KIND_SCROLL, tmw_pkg::BYTE_W'($urandom),
                           tmw_pkg::CELL_ADDR_W'($urandom));
            end
            else if (r < 83)
            begin
                // broken escape sequence, sometimes left open
                queue_put(tmw_pkg::BYTE_ESC);
                n = $urandom_range(1, 3);
                repeat (n)
                begin
                    k = $urandom_range(0, 3);
                    case (k)
                        0:       queue_put(target_letters[$urandom_range(0, 5)]);
                        1:       queue_put(tmw_pkg::BYTE_ESC);
                        2:       queue_put(CH_NO_TARGET);
                        default: queue_put(tmw_pkg::BYTE_W'($urandom_range(0, 255)));
                    endcase
                end
                if ($urandom_range(0, 1) == 1)
                begin
                    queue_put(tmw_pkg::BYTE_END);
                end
            end
            else
            begin
                // noise of any kind
                queue_item(tmw_pkg::KIND_W'($urandom_range(0, 3)), tmw_pkg::BYTE_W'($urandom),
                           tmw_pkg::CELL_ADDR_W'($urandom));
            end
        end

        // close any open escape sequence, then a full line that wraps
        queue_put(tmw_pkg::BYTE_END);
        queue_put(tmw_pkg::BYTE_END);
        queue_put(tmw_pkg::BYTE_CR);
        repeat (COLS)
        begin
            queue_put(tmw_pkg::BYTE_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)));
        end
        queue_item(tmw_pkg::KIND_READ, 8'h00, tmw_pkg::CELL_ADDR_W'(CELLS - COLS - 1));
        items_total = items_to_send.size();

        // reset
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // drain
        while (items_accepted < items_total || status_due.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (status_due.size() != 0)
        begin
            note_failure("expected results left over");
        end

        if (fail_count == 0)
        begin
            $display("** text_mode_terminal_writer: PASSED **");
        end
        else
        begin
            $display("** text_mode_terminal_writer: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/tmw_pkg.sv
hw/rtl/tmw_if.sv
hw/rtl/tmw_ram.sv
hw/rtl/tmw_dp.sv
hw/rtl/tmw_ctrl.sv
hw/rtl/text_mode_terminal_writer.sv
verif/tb_text_mode_terminal_writer.sv
